// File: rtl/sdud_pkg.sv
// ----------------------------------------------------------------------------
// sdud_pkg
// types, register indexes and reset constants for the stall / unjam block
// ----------------------------------------------------------------------------
package sdud_pkg;

  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [31:0] OVERLOAD_HOLD_MS = 32'd5;

  localparam logic        RST_ANTI_JAM_ENABLE    = 1'b1;
  localparam logic [13:0] RST_STALL_SPEED_THRESH = 14'd160;
  localparam logic [15:0] RST_JAM_TIME_MS        = 16'd100;
  localparam logic [15:0] RST_UNJAM_TIME_MS      = 16'd50;
  localparam logic [14:0] RST_UNJAM_VOLTAGE      = 15'h5120; // -12000
  localparam logic [15:0] RST_UNJAM_COOLDOWN_MS  = 16'd2000;
  localparam logic [11:0] RST_TORQUE_THRESHOLD   = 12'd256;
  localparam logic [15:0] RST_LOAD_SETTLE_MS     = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANTI_JAM_ENABLE    = 3'd0,
    REG_STALL_SPEED_THRESH = 3'd1,
    REG_JAM_TIME_MS        = 3'd2,
    REG_UNJAM_TIME_MS      = 3'd3,
    REG_UNJAM_VOLTAGE      = 3'd4,
    REG_UNJAM_COOLDOWN_MS  = 3'd5,
    REG_TORQUE_THRESHOLD   = 3'd6,
    REG_LOAD_SETTLE_MS     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [14:0] value;
    logic               is_speed;
  } drive_t;

  localparam drive_t DRIVE_OFF = '{value: 15'sd0, is_speed: 1'b0};

endpackage

// File: rtl/stall_detect_unjam_drive_core.sv
// ----------------------------------------------------------------------------
// stall_detect_unjam_drive_core
// bottom roller stall detection, timed reverse unjam and top overload stop
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | contents
//  s_axis   | in        | s_tvalid/s_tready  | one control tick
//  m_axis   | out       | m_tvalid/m_tready  | three motor drives and status
//  cfg      | in        | cfg_valid/cfg_ready| register index and write data
//
//  one word per clock while the output is not stalled; the word is computed in the accepting cycle and held
//  in the output register, which is also the held drive state
//  s_tready is high while the output register is empty or being drained
//  cfg_ready is always high
//  synchronous reset clears all timers, the latch and the held drives
// ----------------------------------------------------------------------------
module stall_detect_unjam_drive_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // now_ms, bottom_speed, top_torque, top, middle and bottom command values,
  // loading, clear_overload, zero fill
  input  logic [sdud_pkg::IN_DATA_W-1:0]   s_tdata,
  // is_speed flags of the top, middle and bottom commands
  input  logic [sdud_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // top_drive_value, middle_drive_value, bottom_drive_value,
  // overload_stopped, rumble_pulse, unjam_running
  output logic [sdud_pkg::OUT_DATA_W-1:0]  m_tdata,
  // top_drive_is_speed, middle_drive_is_speed, bottom_drive_is_speed
  output logic [sdud_pkg::OUT_USER_W-1:0]  m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sdud_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdud_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sdud_pkg::*;

  // configuration
  logic        anti_jam_enable;
  logic [13:0] stall_speed_threshold;
  logic [15:0] jam_time_ms;
  logic [15:0] unjam_time_ms;
  logic [14:0] unjam_mv;
  logic [15:0] cooldown_ms;
  logic [11:0] torque_threshold;
  logic [15:0] load_settle_ms;

  // state
  logic [31:0] stall_start,      stall_start_next;
  logic [31:0] last_unjam_end,   last_unjam_end_next;
  logic        unjam_pending,    unjam_pending_next;
  logic [31:0] unjam_start,      unjam_start_next;
  logic [31:0] load_begin,       load_begin_next;
  logic [31:0] overload_start,   overload_start_next;
  logic        overload_latched, overload_latched_next;
  logic        loading_prev;

  // output register, doubles as held drives
  drive_t top_drive,    top_drive_next;
  drive_t middle_drive, middle_drive_next;
  drive_t bottom_drive, bottom_drive_next;
  logic   rumble,  rumble_next;
  logic   running, running_next;

  // input fields
  logic [31:0]        now_ms;
  logic signed [14:0] bottom_speed;
  logic [11:0]        top_torque;
  drive_t             top_cmd, mid_cmd, bot_cmd;
  logic               loading, clear_overload;

  logic        accept;
  logic        monitor, fire, hold;
  logic        stall_cond;
  logic [31:0] unjam_start_eff, stall_start_eff;
  logic        unjam_done;

  assign now_ms         = s_tdata[31:0];
  assign bottom_speed   = s_tdata[46:32];
  assign top_torque     = s_tdata[58:47];
  assign top_cmd        = '{value: s_tdata[73:59],  is_speed: s_tuser[0]};
  assign mid_cmd        = '{value: s_tdata[88:74],  is_speed: s_tuser[1]};
  assign bot_cmd        = '{value: s_tdata[103:89], is_speed: s_tuser[2]};
  assign loading        = s_tdata[104];
  assign clear_overload = s_tdata[105];

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      anti_jam_enable       <= RST_ANTI_JAM_ENABLE;
      stall_speed_threshold <= RST_STALL_SPEED_THRESH;
      jam_time_ms           <= RST_JAM_TIME_MS;
      unjam_time_ms         <= RST_UNJAM_TIME_MS;
      unjam_mv              <= RST_UNJAM_VOLTAGE;
      cooldown_ms           <= RST_UNJAM_COOLDOWN_MS;
      torque_threshold      <= RST_TORQUE_THRESHOLD;
      load_settle_ms        <= RST_LOAD_SETTLE_MS;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ANTI_JAM_ENABLE:    anti_jam_enable       <= cfg_data[0];
        REG_STALL_SPEED_THRESH: stall_speed_threshold <= cfg_data[13:0];
        REG_JAM_TIME_MS:        jam_time_ms           <= cfg_data;
        REG_UNJAM_TIME_MS:      unjam_time_ms         <= cfg_data;
        REG_UNJAM_VOLTAGE:      unjam_mv              <= cfg_data[14:0];
        REG_UNJAM_COOLDOWN_MS:  cooldown_ms           <= cfg_data;
        REG_TORQUE_THRESHOLD:   torque_threshold      <= cfg_data[11:0];
        REG_LOAD_SETTLE_MS:     load_settle_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    stall_start_next      = stall_start;
    last_unjam_end_next   = last_unjam_end;
    unjam_pending_next    = unjam_pending;
    unjam_start_next      = unjam_start;
    overload_start_next   = overload_start;
    overload_latched_next = clear_overload ? 1'b0 : overload_latched;
    fire                  = 1'b0;
    hold                  = 1'b0;
    unjam_start_eff       = '0;
    stall_start_eff       = '0;
    unjam_done            = 1'b0;
    stall_cond            = 1'b0;
    top_drive_next        = top_drive;
    middle_drive_next     = middle_drive;
    bottom_drive_next     = bottom_drive;
    running_next          = 1'b0;

    // loading start time
    if (!loading) begin
      load_begin_next = '0;
    end else if (!loading_prev) begin
      load_begin_next = now_ms;
    end else begin
      load_begin_next = load_begin;
    end

    // top overload timing
    monitor = loading && (load_begin_next != '0) &&
              ((now_ms - load_begin_next) >= {16'd0, load_settle_ms});
    if (monitor) begin
      if (top_torque > torque_threshold) begin
        if (overload_start == '0) begin
          overload_start_next = now_ms;
        end else if ((now_ms - overload_start) >= OVERLOAD_HOLD_MS) begin
          fire                  = 1'b1;
          overload_latched_next = 1'b1;
          top_drive_next        = DRIVE_OFF;
        end
      end else begin
        overload_start_next = '0;
      end
    end

    if (unjam_pending) begin
      running_next      = 1'b1;
      unjam_start_eff   = (unjam_start == '0) ? now_ms : unjam_start;
      top_drive_next    = DRIVE_OFF;
      middle_drive_next = DRIVE_OFF;
      bottom_drive_next = '{value: unjam_mv, is_speed: 1'b0};
      unjam_done        = (now_ms - unjam_start_eff) >= {16'd0, unjam_time_ms};
      if (unjam_done) begin
        unjam_pending_next  = 1'b0;
        unjam_start_next    = '0;
        last_unjam_end_next = now_ms;
      end else begin
        unjam_start_next = unjam_start_eff;
      end
    end else begin
      stall_cond = ($signed({bottom_speed[14], bottom_speed}) <
                    $signed({2'b00, stall_speed_threshold})) &&
                   !bot_cmd.value[14] && (bot_cmd.value != '0);
      if (!anti_jam_enable || !stall_cond) begin
        stall_start_next = '0;
      end else begin
        stall_start_eff  = (stall_start == '0) ? now_ms : stall_start;
        stall_start_next = stall_start_eff;
        if (((now_ms - stall_start_eff) > {16'd0, jam_time_ms}) &&
            ((now_ms - last_unjam_end) >= {16'd0, cooldown_ms})) begin
          unjam_pending_next = 1'b1;
          stall_start_next   = '0;
          hold               = 1'b1;
        end
      end
      if (!hold) begin
        top_drive_next    = overload_latched_next ? DRIVE_OFF : top_cmd;
        middle_drive_next = mid_cmd;
        bottom_drive_next = bot_cmd;
      end
    end
    rumble_next = fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_start      <= '0;
      last_unjam_end   <= '0;
      unjam_pending    <= 1'b0;
      unjam_start      <= '0;
      load_begin       <= '0;
      overload_start   <= '0;
      overload_latched <= 1'b0;
      loading_prev     <= 1'b0;
      top_drive        <= DRIVE_OFF;
      middle_drive     <= DRIVE_OFF;
      bottom_drive     <= DRIVE_OFF;
      rumble           <= 1'b0;
      running          <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (accept) begin
        stall_start      <= stall_start_next;
        last_unjam_end   <= last_unjam_end_next;
        unjam_pending    <= unjam_pending_next;
        unjam_start      <= unjam_start_next;
        load_begin       <= load_begin_next;
        overload_start   <= overload_start_next;
        overload_latched <= overload_latched_next;
        loading_prev     <= loading;
        top_drive        <= top_drive_next;
        middle_drive     <= middle_drive_next;
        bottom_drive     <= bottom_drive_next;
        rumble           <= rumble_next;
        running          <= running_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {running, rumble, overload_latched,
                    bottom_drive.value, middle_drive.value, top_drive.value};
  assign m_tuser = {bottom_drive.is_speed, middle_drive.is_speed, top_drive.is_speed};

endmodule

// File: rtl/sdud_checker.sv
// ----------------------------------------------------------------------------
// sdud_checker
// port-level checks on the output words of the stall / unjam block
// ----------------------------------------------------------------------------
module sdud_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [sdud_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [sdud_pkg::OUT_USER_W-1:0] m_tuser
);
  import sdud_pkg::*;

  // rumble only on a word whose overload stop is latched
  a_rumble_latched: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[46]) |-> m_tdata[45])
    else $error("rumble without overload stop");

  // latched stop keeps the top motor at zero volts
  a_stop_top_off: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[45]) |-> (m_tdata[14:0] == '0 && !m_tuser[0]))
    else $error("top drive active while stopped");

  // unjam drives top and middle at zero volts, bottom in voltage mode
  a_unjam_drive: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[47]) |->
      (m_tdata[14:0] == '0 && m_tdata[29:15] == '0 && m_tuser == '0))
    else $error("unjam word with wrong drives");

  // a stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("output word dropped or changed under stall");

endmodule

bind stall_detect_unjam_drive_core sdud_checker u_sdud_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: verif/stall_detect_unjam_drive_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stall_detect_unjam_drive_core_tb
// drives control ticks through the stream port, predicts the three motor
// drives and status flags of every tick in step with the block, and checks
// each output word against the oldest prediction; a directed table is
// followed by randomized phases under several register settings
// ----------------------------------------------------------------------------
module stall_detect_unjam_drive_core_tb;
  import sdud_pkg::*;

  typedef struct packed {
    logic [31:0]        now;
    logic signed [14:0] speed;
    logic [11:0]        torque;
    drive_t             top_cmd;
    drive_t             mid_cmd;
    drive_t             bot_cmd;
    logic               loading;
    logic               clear;
  } tick_t;

  typedef struct packed {
    drive_t top;
    drive_t mid;
    drive_t bot;
    logic   overload;
    logic   rumble;
    logic   unjam;
  } drive_word_t;

  typedef struct {
    tick_t       tick;
    bit          typed;
    drive_word_t word;
  } table_row_t;

  localparam int PRESSURE_CYCLES = 300;
  localparam int PHASE_TICKS     = 200;
  localparam int NUM_PHASES      = 8;
  localparam int PEND_DEPTH      = 16;
  localparam int MAX_ROWS        = 64;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [IN_USER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // register shadow
  logic               jam_en;
  logic [13:0]        stall_thr;
  logic [15:0]        jam_ms;
  logic [15:0]        unjam_ms;
  logic signed [14:0] unjam_mv;
  logic [15:0]        cool_ms;
  logic [11:0]        torque_thr;
  logic [15:0]        settle_ms;

  // predicted block state
  logic [31:0] stall_t0;
  logic [31:0] unjam_end_t;
  logic [31:0] unjam_t0;
  logic [31:0] load_t0;
  logic [31:0] ovl_t0;
  logic        unjam_armed;
  logic        ovl_latch;
  logic        load_prev;
  drive_word_t held;

  drive_word_t pend_fifo[PEND_DEPTH];
  int          pend_wr        = 0;
  int          pend_rd        = 0;
  table_row_t  dir_rows[MAX_ROWS];
  int          row_count      = 0;
  int          mismatch_count = 0;
  int          words_seen     = 0;
  bit          idle_en        = 1'b1;
  bit          pressure_done  = 1'b0;

  stall_detect_unjam_drive_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic reset_model();
    jam_en      = RST_ANTI_JAM_ENABLE;
    stall_thr   = RST_STALL_SPEED_THRESH;
    jam_ms      = RST_JAM_TIME_MS;
    unjam_ms    = RST_UNJAM_TIME_MS;
    unjam_mv    = RST_UNJAM_VOLTAGE;
    cool_ms     = RST_UNJAM_COOLDOWN_MS;
    torque_thr  = RST_TORQUE_THRESHOLD;
    settle_ms   = RST_LOAD_SETTLE_MS;
    stall_t0    = '0;
    unjam_end_t = '0;
    unjam_t0    = '0;
    load_t0     = '0;
    ovl_t0      = '0;
    unjam_armed = 1'b0;
    ovl_latch   = 1'b0;
    load_prev   = 1'b0;
    held        = '0;
  endtask

  task automatic apply_reg(input reg_idx_t idx, input logic [15:0] v);
    case (idx)
      REG_ANTI_JAM_ENABLE:    jam_en     = v[0];
      REG_STALL_SPEED_THRESH: stall_thr  = v[13:0];
      REG_JAM_TIME_MS:        jam_ms     = v;
      REG_UNJAM_TIME_MS:      unjam_ms   = v;
      REG_UNJAM_VOLTAGE:      unjam_mv   = v[14:0];
      REG_UNJAM_COOLDOWN_MS:  cool_ms    = v;
      REG_TORQUE_THRESHOLD:   torque_thr = v[11:0];
      REG_LOAD_SETTLE_MS:     settle_ms  = v;
      default: ;
    endcase
  endtask

  task automatic predict_drives(input tick_t t, output drive_word_t w);
    drive_word_t d;
    logic        hold;
    int          spd;
    int          thr;
    d          = held;
    d.overload = 1'b0;
    d.rumble   = 1'b0;
    d.unjam    = 1'b0;
    hold       = 1'b0;
    spd        = int'(t.speed);
    thr        = {18'd0, stall_thr};

    if (t.clear) ovl_latch = 1'b0;
    if (!t.loading) load_t0 = '0;
    else if (!load_prev) load_t0 = t.now;
    load_prev = t.loading;

    // overload timing only after the settle time
    if (t.loading && load_t0 != 0 && (t.now - load_t0) >= {16'd0, settle_ms}) begin
      if (t.torque > torque_thr) begin
        if (ovl_t0 == 0) begin
          ovl_t0 = t.now;
        end else if ((t.now - ovl_t0) >= OVERLOAD_HOLD_MS) begin
          ovl_latch = 1'b1;
          d.rumble  = 1'b1;
          d.top     = DRIVE_OFF;
        end
      end else begin
        ovl_t0 = '0;
      end
    end

    if (unjam_armed) begin
      d.unjam = 1'b1;
      if (unjam_t0 == 0) unjam_t0 = t.now;
      d.top          = DRIVE_OFF;
      d.mid          = DRIVE_OFF;
      d.bot.value    = unjam_mv;
      d.bot.is_speed = 1'b0;
      if ((t.now - unjam_t0) >= {16'd0, unjam_ms}) begin
        unjam_armed = 1'b0;
        unjam_t0    = '0;
        unjam_end_t = t.now;
      end
    end else begin
      if (!jam_en) begin
        stall_t0 = '0;
      end else if (spd < thr && $signed(t.bot_cmd.value) > 0) begin
        if (stall_t0 == 0) stall_t0 = t.now;
        if ((t.now - stall_t0) > {16'd0, jam_ms} &&
            (t.now - unjam_end_t) >= {16'd0, cool_ms}) begin
          unjam_armed = 1'b1;
          stall_t0    = '0;
          hold        = 1'b1;
        end
      end else begin
        stall_t0 = '0;
      end
      // start tick holds the previous drives
      if (!hold) begin
        d.top = t.top_cmd;
        d.mid = t.mid_cmd;
        d.bot = t.bot_cmd;
        if (ovl_latch) d.top = DRIVE_OFF;
      end
    end
    d.overload = ovl_latch;
    held       = d;
    w          = d;
  endtask

  task automatic write_one(input reg_idx_t idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, v);
  endtask

  task automatic write_regs(input int en, input int thr, input int jam, input int unj,
                            input int volt, input int cool, input int torq,
                            input int settle);
    write_one(REG_ANTI_JAM_ENABLE, en[15:0]);
    write_one(REG_STALL_SPEED_THRESH, thr[15:0]);
    write_one(REG_JAM_TIME_MS, jam[15:0]);
    write_one(REG_UNJAM_TIME_MS, unj[15:0]);
    write_one(REG_UNJAM_VOLTAGE, volt[15:0]);
    write_one(REG_UNJAM_COOLDOWN_MS, cool[15:0]);
    write_one(REG_TORQUE_THRESHOLD, torq[15:0]);
    write_one(REG_LOAD_SETTLE_MS, settle[15:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input tick_t t, input bit typed, input drive_word_t lit);
    drive_word_t w;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, t.clear, t.loading, t.bot_cmd.value, t.mid_cmd.value,
                 t.top_cmd.value, t.torque, t.speed, t.now};
    s_tuser  <= {t.bot_cmd.is_speed, t.mid_cmd.is_speed, t.top_cmd.is_speed};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_drives(t, w);
    pend_fifo[pend_wr % PEND_DEPTH] = typed ? lit : w;
    pend_wr++;
  endtask

  task automatic add_row(input logic [31:0] now, input int speed, input int torque,
                         input int tv, input bit ts, input int mv, input bit ms,
                         input int bv, input bit bs, input bit ld, input bit clr);
    table_row_t r;
    r.tick.now              = now;
    r.tick.speed            = speed[14:0];
    r.tick.torque           = torque[11:0];
    r.tick.top_cmd.value    = tv[14:0];
    r.tick.top_cmd.is_speed = ts;
    r.tick.mid_cmd.value    = mv[14:0];
    r.tick.mid_cmd.is_speed = ms;
    r.tick.bot_cmd.value    = bv[14:0];
    r.tick.bot_cmd.is_speed = bs;
    r.tick.loading          = ld;
    r.tick.clear            = clr;
    r.typed                 = 1'b0;
    r.word                  = '0;
    dir_rows[row_count]     = r;
    row_count++;
  endtask

  task automatic mark_typed(input int tv, input bit ts, input int mv, input bit ms,
                            input int bv, input bit bs, input bit ovl, input bit rum,
                            input bit run);
    int k;
    k = row_count - 1;
    dir_rows[k].typed              = 1'b1;
    dir_rows[k].word.top.value     = tv[14:0];
    dir_rows[k].word.top.is_speed  = ts;
    dir_rows[k].word.mid.value     = mv[14:0];
    dir_rows[k].word.mid.is_speed  = ms;
    dir_rows[k].word.bot.value     = bv[14:0];
    dir_rows[k].word.bot.is_speed  = bs;
    dir_rows[k].word.overload      = ovl;
    dir_rows[k].word.rumble        = rum;
    dir_rows[k].word.unjam         = run;
  endtask

  always @(posedge clk) begin : word_check
    drive_word_t got;
    drive_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.top.value    = m_tdata[14:0];
      got.mid.value    = m_tdata[29:15];
      got.bot.value    = m_tdata[44:30];
      got.overload     = m_tdata[45];
      got.rumble       = m_tdata[46];
      got.unjam        = m_tdata[47];
      got.top.is_speed = m_tuser[0];
      got.mid.is_speed = m_tuser[1];
      got.bot.is_speed = m_tuser[2];
      words_seen++;
      if (pend_wr == pend_rd) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word %0d", words_seen);
      end else begin
        want = pend_fifo[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (got.top !== want.top || got.mid !== want.mid || got.bot !== want.bot ||
            got.overload !== want.overload || got.rumble !== want.rumble ||
            got.unjam !== want.unjam) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("word %0d exp top %0d/%0b mid %0d/%0b bot %0d/%0b ovl %0b rum %0b unj %0b",
                     words_seen, want.top.value, want.top.is_speed, want.mid.value,
                     want.mid.is_speed, want.bot.value, want.bot.is_speed,
                     want.overload, want.rumble, want.unjam);
            $display("word %0d got top %0d/%0b mid %0d/%0b bot %0d/%0b ovl %0b rum %0b unj %0b",
                     words_seen, got.top.value, got.top.is_speed, got.mid.value,
                     got.mid.is_speed, got.bot.value, got.bot.is_speed,
                     got.overload, got.rumble, got.unjam);
          end
        end
      end
    end
  end

  initial begin : drain
    int burst;
    burst = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (!pressure_done && words_seen >= 400) begin
        // long hold-off so the output register fills and stalls the input
        pressure_done = 1'b1;
        m_tready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end else if (burst > 0) begin
        burst--;
        m_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    tick_t       t;
    drive_word_t none;
    logic [31:0] clock_ms;
    bit          torque_hi;
    bit          load_on;
    int          phase;
    int          n;
    int          lo;
    int          hi;
    int          step_max;
    none      = '0;
    torque_hi = 1'b0;
    load_on   = 1'b0;
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes pass through after reset
    add_row(32'd1, 16383, 4095, 12000, 1, -12000, 1, 12000, 1, 0, 0);
    mark_typed(12000, 1, -12000, 1, 12000, 1, 0, 0, 0);
    add_row(32'd2, -16384, 0, -12000, 0, 12000, 0, -12000, 0, 0, 0);
    mark_typed(-12000, 0, 12000, 0, -12000, 0, 0, 0, 0);
    // stall timer set at time zero reads as idle
    add_row(32'd0, 0, 100, 3000, 0, 3000, 0, 5000, 0, 0, 0);
    add_row(32'd10, 0, 100, 3000, 0, 3000, 0, 5000, 0, 0, 0);
    // jam time passed, cooldown not yet
    add_row(32'd200, 0, 100, 3000, 0, 3000, 0, 5000, 0, 0, 0);
    // unjam start tick holds the drives
    add_row(32'd2500, 0, 100, 3000, 0, 3000, 0, 5000, 0, 0, 0);
    add_row(32'd2501, 0, 100, 3000, 0, 3000, 0, 5000, 0, 0, 0);
    mark_typed(0, 0, 0, 0, -12000, 0, 0, 0, 1);
    add_row(32'd2551, 0, 100, 3000, 0, 3000, 0, 5000, 0, 0, 0);
    add_row(32'd2552, 0, 100, 3000, 0, 3000, 0, 5000, 0, 0, 0);
    // loading, settle, overload stop
    add_row(32'd3000, 0, 0, 3000, 0, 3000, 0, 5000, 0, 1, 0);
    add_row(32'd4000, 0, 4095, 3000, 0, 3000, 0, 5000, 0, 1, 0);
    add_row(32'd4005, 0, 4095, 3000, 0, 3000, 0, 5000, 0, 1, 0);
    mark_typed(0, 0, 3000, 0, 5000, 0, 1, 1, 0);
    // stop fires on the unjam start tick
    add_row(32'd4600, 0, 4095, 3000, 1, 3000, 1, 5000, 1, 1, 0);
    add_row(32'd4601, 0, 0, 3000, 1, 3000, 1, 5000, 1, 1, 1);
    add_row(32'd4602, 0, 4095, 3000, 1, 3000, 1, 5000, 1, 1, 0);
    // clear and new fire on the same tick
    add_row(32'd4607, 0, 4095, 3000, 1, 3000, 1, 5000, 1, 1, 1);
    add_row(32'd4608, 0, 0, 3000, 0, 3000, 0, 5000, 0, 0, 0);
    // loading begun at time zero never monitors
    add_row(32'd0, 2000, 4095, 100, 0, 200, 0, 3000, 0, 1, 0);
    add_row(32'd1, 2000, 4095, 100, 0, 200, 0, 3000, 0, 1, 0);
    add_row(32'd2000, 2000, 4095, 100, 0, 200, 0, 3000, 0, 1, 0);
    // stall across the clock wrap
    add_row(32'hFFFF_FFFF, -1, 0, 100, 0, 200, 0, 1, 0, 0, 0);
    add_row(32'h0000_0063, -1, 0, 100, 0, 200, 0, 1, 0, 0, 0);
    add_row(32'h0000_0064, -1, 0, 100, 0, 200, 0, 1, 0, 0, 0);
    for (int i = 0; i < row_count; i++) begin
      send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].word);
    end

    clock_ms = 32'd5000;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      s_tvalid <= 1'b0;
      while (pend_wr != pend_rd) @(posedge clk);
      case (phase)
        0: ;
        1: write_regs(1, 160, 10, 5, -12000, 20, 256, 10);
        2: write_regs(0, 8000, 3, 2, 5000, 0, 2000, 5);
        3: write_regs(1, 16383, 0, 1, 12000, 0, 0, 0);
        4: write_regs(1, 0, 65535, 65535, -12000, 65535, 4095, 65535);
        7: write_regs(1, 160, 20, 8, -12000, 50, 256, 15);
        default: write_regs(int'($urandom_range(0, 3) != 0), $urandom_range(0, 4000),
                            $urandom_range(0, 30), $urandom_range(1, 20),
                            int'($urandom_range(0, 24000)) - 12000,
                            $urandom_range(0, 100), $urandom_range(0, 4095),
                            $urandom_range(0, 30));
      endcase
      idle_en  = (phase != 3 && phase != NUM_PHASES - 1);
      step_max = (phase == 4) ? 20000 : 6;
      if (phase == 2) clock_ms = 32'hFFFF_FF00;

      for (n = 0; n < PHASE_TICKS; n++) begin
        if ($urandom_range(0, 63) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, step_max);
        t.now = clock_ms;

        case ($urandom_range(0, 3))
          0: begin
            lo = $urandom;
          end
          1, 2: begin
            lo = int'($urandom_range(0, int'(stall_thr) + 199)) - 200;
          end
          default: begin
            lo = int'(stall_thr) - 2 + int'($urandom_range(0, 4));
            if (lo > 16383) lo = 16383;
          end
        endcase
        t.speed = lo[14:0];

        if ($urandom_range(0, 19) == 0) torque_hi = !torque_hi;
        if ($urandom_range(0, 3) == 0) begin
          lo = $urandom;
        end else if (torque_hi) begin
          hi = (torque_thr == 12'hFFF) ? 4095 : int'(torque_thr) + 1;
          lo = $urandom_range(hi, 4095);
        end else begin
          lo = $urandom_range(0, torque_thr);
        end
        t.torque = lo[11:0];

        lo = int'($urandom_range(0, 24000)) - 12000;
        t.top_cmd.value    = lo[14:0];
        t.top_cmd.is_speed = ($urandom_range(0, 1) != 0);
        lo = int'($urandom_range(0, 24000)) - 12000;
        t.mid_cmd.value    = lo[14:0];
        t.mid_cmd.is_speed = ($urandom_range(0, 1) != 0);
        if ($urandom_range(0, 3) != 0) lo = $urandom_range(1, 12000);
        else lo = -int'($urandom_range(0, 12000));
        t.bot_cmd.value    = lo[14:0];
        t.bot_cmd.is_speed = ($urandom_range(0, 1) != 0);

        if ($urandom_range(0, 39) == 0) load_on = !load_on;
        t.loading = load_on;
        t.clear   = ($urandom_range(0, 24) == 0);

        if (idle_en && $urandom_range(0, 3) == 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        send_tick(t, 1'b0, none);
      end
    end

    s_tvalid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
